/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file of the move-to-front coder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is held.
`define MTF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mtf assertion failed");

// Check that a condition in one cycle implies a condition in the next.
`define MTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtf assertion failed");

`endif

/* rtl/mtf_pkg.sv */
// Shared types and constants of the move-to-front coder.
package mtf_pkg;

	// Width of a symbol or a list position
	localparam int SYM_W = 8;

	// Direction register codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Control of one list cell
	typedef struct packed {
		logic load_id;   // reload the cell's identity value
		logic shift;     // take the neighbour's value
	} cell_ctrl_t;

endpackage

/* rtl/mtf_cell.sv */
// One entry of the symbol list: holds a symbol and takes its neighbour's value on a shift.
module mtf_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mtf_pkg::cell_ctrl_t        ctrl,
	input  logic [mtf_pkg::SYM_W-1:0]  d,
	output logic [mtf_pkg::SYM_W-1:0]  q
);

	logic [mtf_pkg::SYM_W-1:0] sym_q;

	// Reload identity at block start, otherwise advance with the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= mtf_pkg::SYM_W'(IDX);
		end else if (ctrl.load_id) begin
			sym_q <= mtf_pkg::SYM_W'(IDX);
		end else if (ctrl.shift) begin
			sym_q <= d;
		end
	end

	assign q = sym_q;

endmodule

/* rtl/move_to_front_coder.sv */
// Top level of the move-to-front coder: a rotating row of list cells and its sequencer.
//
// Channel   Direction  Handshake                 Content
// s_axis    in         s_axis_tvalid/tready      symbol or position, block start flag
// m_axis    out        m_axis_tvalid/tready      coded value
// cfg       in         cfg_valid/cfg_ready       direction bit
//
// Each item is accepted and then handled in one pass in which the
// whole list rotates once through the row of cells, one entry per cycle past the head.
// Reset loads the identity list at once; no clearing pass is needed.
// The pass halts on its final cycle while a previous result still waits on m_axis;
// a new item is accepted while a result waits.
module move_to_front_coder #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tuser,   // [0] block_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] coded
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int N  = ALPHABET_SIZE;
	localparam int IW = (N > 2) ? $clog2(N) : 1;
	localparam int SW = mtf_pkg::SYM_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic                dir_q;
	logic                mode_q;
	logic                in_range_q;
	logic                found_q;
	logic [SW-1:0]       key_q;
	logic [SW-1:0]       carry_q;
	logic [SW-1:0]       moved_q;
	logic [SW-1:0]       pos_res_q;
	logic [IW-1:0]       cnt_q;
	logic                out_valid_q;
	logic [SW-1:0]       out_data_q;

	logic [SW-1:0]       cell_q [N];
	logic [SW-1:0]       cell_d [N];
	mtf_pkg::cell_ctrl_t cell_ctrl;

	logic                in_acc;
	logic                out_free;
	logic                last;
	logic                adv;
	logic [SW-1:0]       head;
	logic [SW-1:0]       cnt_sym;
	logic                match;
	logic                mv;
	logic [SW-1:0]       feed;
	logic [SW-1:0]       moved_now;
	logic                fix_front;
	logic [SW-1:0]       result;
	logic                sym_in_range;
	logic [SW-1:0]       dec_pos;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign head     = cell_q[0];
	assign cnt_sym  = SW'(cnt_q);
	assign last     = (cnt_q == IW'(N - 1));
	assign adv      = (state_q == ST_RUN) && !(last && !out_free);

	// Input field checks against the alphabet
	assign sym_in_range = ({1'b0, s_axis_tdata} < (SW + 1)'(N));
	assign dec_pos      = sym_in_range ? s_axis_tdata : SW'(N - 1);

	// Head of the row: match, feed to the tail and the symbol moving to the front
	always_comb begin
		if (mode_q == mtf_pkg::DIR_ENCODE) begin
			mv        = in_range_q && !found_q;
			match     = mv && (head == key_q);
			fix_front = in_range_q;
		end else begin
			mv        = (cnt_sym <= key_q);
			match     = (cnt_sym == key_q);
			fix_front = 1'b1;
		end
		feed      = mv ? carry_q : head;
		moved_now = match ? head : moved_q;
		if (mode_q == mtf_pkg::DIR_ENCODE) begin
			if (!in_range_q) begin
				result = '0;
			end else begin
				result = match ? cnt_sym : pos_res_q;
			end
		end else begin
			result = moved_now;
		end
	end

	// Cell controls
	assign cell_ctrl.load_id = in_acc && s_axis_tuser;
	assign cell_ctrl.shift   = adv;

	// Row of cells, rotating towards the head
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_tail
			assign cell_d[i] = feed;
		end else if (i == 0) begin : g_front
			assign cell_d[i] = (last && fix_front) ? moved_now : cell_q[i + 1];
		end else begin : g_mid
			assign cell_d[i] = cell_q[i + 1];
		end
		mtf_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= mtf_pkg::DIR_ENCODE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dir_q <= cfg_data;
			end
			// Raise the result beat at the end of a pass, drop it once taken
			out_valid_q <= (adv && last) || (out_valid_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						cnt_q <= cnt_q + IW'(1);
						if (match) begin
							found_q <= 1'b1;
						end
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload, carried entry and result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q     <= dir_q;
			in_range_q <= (dir_q == mtf_pkg::DIR_DECODE) || sym_in_range;
			key_q      <= (dir_q == mtf_pkg::DIR_DECODE) ? dec_pos : s_axis_tdata;
		end
		if (adv) begin
			carry_q <= head;
			if (match) begin
				moved_q   <= head;
				pos_res_q <= cnt_sym;
			end
			if (last) begin
				out_data_q <= result;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/mtf_checker.sv */
// Port-level checks of the move-to-front coder, bound to its top level.
`include "assert_macros.svh"

module mtf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	logic s_acc;
	logic m_stall;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign m_stall = m_axis_tvalid && !m_axis_tready;

	// Hold a stalled result beat
	`MTF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_stall, m_axis_tvalid)
	`MTF_ASSERT_NEXT(a_out_stable, clk, arst_n, m_stall, $stable(m_axis_tdata))
	// Take one beat at a time: the input closes while a pass runs
	`MTF_ASSERT_NEXT(a_in_busy, clk, arst_n, s_acc, !s_axis_tready)
	// A result never appears in the cycle right after a beat is taken
	`MTF_ASSERT_NEXT(a_no_early_out, clk, arst_n, s_acc, !$rose(m_axis_tvalid))

endmodule

bind move_to_front_coder mtf_checker u_mtf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* dv/move_to_front_checker.sv */
// Checker of the move-to-front coder: watches its channels, predicts each coded beat and compares.
module move_to_front_checker #(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tuser,   // [0] block_start
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // [7:0] coded
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          fault_count,
	output int          pending_count
);

	localparam int SW = mtf_pkg::SYM_W;

	logic [SW-1:0] symbol_order [ALPHABET_SIZE];
	logic          direction;
	logic [SW-1:0] expected_coded [$];
	int            faults;
	int            pending;
	int            beat_no;

	assign fault_count   = faults;
	assign pending_count = pending;

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what);
		$display("[%0t] coded beat %0d: %s", $realtime, beat_no, what);
		faults++;
	endtask

	// Reload the list with the identity order
	function automatic void restore_identity();
		for (int i = 0; i < ALPHABET_SIZE; i++)
			symbol_order[i] = i[SW-1:0];
	endfunction

	// Code one item and promote its entry to the front of the list
	function automatic logic [SW-1:0] code_symbol(logic [SW-1:0] value, logic start);
		int            pos;
		logic [SW-1:0] moved;
		logic [SW-1:0] coded;
		if (start)
			restore_identity();
		coded = '0;
		pos   = -1;
		if (direction == mtf_pkg::DIR_ENCODE) begin
			for (int i = 0; i < ALPHABET_SIZE; i++)
				if (pos < 0 && symbol_order[i] == value)
					pos = i;
			if (pos >= 0)
				coded = pos[SW-1:0];
		end else begin
			pos   = (value >= ALPHABET_SIZE) ? ALPHABET_SIZE - 1 : int'(value);
			coded = symbol_order[pos];
		end
		if (pos > 0) begin
			moved = symbol_order[pos];
			for (int i = pos; i > 0; i--)
				symbol_order[i] = symbol_order[i-1];
			symbol_order[0] = moved;
		end
		return coded;
	endfunction

	// Retire results before predicting new ones: a result never leaves on its own item's edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_identity();
			direction = mtf_pkg::DIR_ENCODE;
			expected_coded.delete();
			faults  = 0;
			pending = 0;
			beat_no = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_coded.size() == 0) begin
					report_mismatch($sformatf("unexpected result 0x%02h", m_axis_tdata));
				end else begin
					logic [SW-1:0] want;
					want = expected_coded.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("coded 0x%02h, expected 0x%02h",
							m_axis_tdata, want));
				end
				beat_no++;
			end
			if (cfg_valid && cfg_ready)
				direction = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_coded.push_back(code_symbol(s_axis_tdata, s_axis_tuser));
			pending = expected_coded.size();
		end
	end

endmodule

/* dv/move_to_front_coder_tb.sv */
// Testbench top of the move-to-front coder: clock, reset, stimulus and verdict.
module move_to_front_coder_tb;

	localparam int ALPHABET_SIZE = 256;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASE_ITEMS   = 120;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] symbol
	logic        s_axis_tuser;   // [0] block_start
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [7:0] coded
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	int          fault_count;
	int          pending_count;
	int          cycle_count;
	logic        sender_steady;

	move_to_front_coder #(.ALPHABET_SIZE(ALPHABET_SIZE)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	move_to_front_checker #(.ALPHABET_SIZE(ALPHABET_SIZE)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fault_count   (fault_count),
		.pending_count (pending_count)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall the result side at random before each beat, with stall-free stretches
	initial begin
		int stall;
		int steady_left;
		steady_left = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (steady_left > 0) begin
				steady_left--;
				stall = 0;
			end else if ($urandom_range(0, 7) == 0) begin
				steady_left = $urandom_range(4, 20);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 7);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			@(negedge clk);
		end
	end

	// Offer a beat after a random gap unless steady; return at the negedge after acceptance
	task automatic send_item(input logic [7:0] value, input logic start);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= value;
		s_axis_tuser  <= start;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	// Drain all results, then write the direction register
	task automatic set_direction(input logic dir);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		cfg_data  <= dir;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random blocks: mostly well-formed runs opened by a block start, some without one
	task automatic send_blocks(input int count, input logic dir);
		int          sent;
		int          run_len;
		logic [7:0]  base;
		logic [7:0]  value;
		logic        start;
		sent = 0;
		while (sent < count) begin
			run_len       = $urandom_range(1, 40);
			base          = 8'($urandom_range(0, 255));
			sender_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < run_len && sent < count; i++) begin
				if (i == 0)
					start = ($urandom_range(0, 7) != 0);
				else
					start = ($urandom_range(0, 31) == 0);
				if (dir == mtf_pkg::DIR_ENCODE)
					value = ($urandom_range(0, 2) != 0)
						? 8'(32'(base) + $urandom_range(0, 15))
						: 8'($urandom_range(0, 255));
				else
					value = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 7))
						: 8'($urandom_range(0, 255));
				send_item(value, start);
				sent++;
			end
		end
		sender_steady = 1'b0;
	endtask

	// Stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = mtf_pkg::DIR_ENCODE;
		cycle_count   = 0;
		sender_steady = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Encode: list straight from reset, extremes, repeats and block restarts
		set_direction(mtf_pkg::DIR_ENCODE);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hFF, 1'b1);
		send_blocks(PHASE_ITEMS, mtf_pkg::DIR_ENCODE);

		// Decode: front, back and middle positions, block restarts
		set_direction(mtf_pkg::DIR_DECODE);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hAA, 1'b1);
		send_item(8'h55, 1'b0);
		send_blocks(PHASE_ITEMS, mtf_pkg::DIR_DECODE);

		// Switch back and forth with the list carried over
		set_direction(mtf_pkg::DIR_ENCODE);
		send_blocks(PHASE_ITEMS, mtf_pkg::DIR_ENCODE);
		set_direction(mtf_pkg::DIR_DECODE);
		send_blocks(PHASE_ITEMS, mtf_pkg::DIR_DECODE);

		// Drain and let the block settle
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		repeat (ALPHABET_SIZE + 8) @(negedge clk);
		if (fault_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/move_to_front_coder.sv
rtl/mtf_checker.sv
dv/move_to_front_checker.sv
dv/move_to_front_coder_tb.sv
